// ===== rtl/ssd_pkg.sv =====
// Shared types, codes and segment tables for the seven-segment encoder.
// No dependencies; used by every module of the encoder.
`timescale 1ns / 1ps

package ssd_pkg;

    localparam logic [1:0] ACT_UNSIGNED = 2'd0;
    localparam logic [1:0] ACT_SIGNED   = 2'd1;
    localparam logic [1:0] ACT_TEXT     = 2'd2;

    localparam logic [1:0] KIND_NUM  = 2'd0;
    localparam logic [1:0] KIND_OFLO = 2'd1;
    localparam logic [1:0] KIND_UFLO = 2'd2;
    localparam logic [1:0] KIND_TEXT = 2'd3;

    localparam int MAG_W = 14;

    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_MINUS = 8'h40;

    // byte 0 is the leftmost digit
    localparam logic [3:0][7:0] PAT_OFLO = 32'h5c38715c;
    localparam logic [3:0][7:0] PAT_UFLO = 32'h5c38711c;

    typedef logic [3:0][7:0] seg4_t;

    typedef struct packed {
        logic [7:0] chip;
        logic [1:0] kind;
        logic       neg;
        logic       ge1000;
        logic       ge100;
        logic       ge10;
        seg4_t      text_seg;
    } ctl_t;

    typedef struct packed {
        logic [3:0]       digit;
        logic [MAG_W-1:0] rest;
    } dstep_t;

    // One decimal digit: parallel compares against the multiples of weight.
    function automatic dstep_t digit_step(logic [MAG_W-1:0] rem, logic [MAG_W-1:0] weight);
        dstep_t           r;
        logic [MAG_W-1:0] prod;
        r.digit = 4'd0;
        r.rest  = rem;
        for (int k = 1; k < 10; k++) begin
            prod = MAG_W'(MAG_W'(k) * weight);
            if (rem >= prod) begin
                r.digit = 4'(k);
                r.rest  = rem - prod;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] digit_seg(logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0: s = 8'hbb;
            4'd1: s = 8'ha0;
            4'd2: s = 8'h37;
            4'd3: s = 8'hb5;
            4'd4: s = 8'hac;
            4'd5: s = 8'h9d;
            4'd6: s = 8'h9f;
            4'd7: s = 8'hb0;
            4'd8: s = 8'hbf;
            4'd9: s = 8'hbd;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] alpha_seg(logic [4:0] a);
        logic [7:0] s;
        unique case (a)
            5'd0:  s = 8'h5f;
            5'd1:  s = 8'h7c;
            5'd2:  s = 8'h58;
            5'd3:  s = 8'h5e;
            5'd4:  s = 8'h7b;
            5'd5:  s = 8'h71;
            5'd6:  s = 8'h6f;
            5'd7:  s = 8'h74;
            5'd8:  s = 8'h04;
            5'd9:  s = 8'h0c;
            5'd10: s = 8'h76;
            5'd11: s = 8'h38;
            5'd12: s = 8'h54;
            5'd13: s = 8'h54;
            5'd14: s = 8'h5c;
            5'd15: s = 8'h73;
            5'd16: s = 8'h67;
            5'd17: s = 8'h50;
            5'd18: s = 8'h6d;
            5'd19: s = 8'h78;
            5'd20: s = 8'h1c;
            5'd21: s = 8'h3e;
            5'd22: s = 8'h7e;
            5'd23: s = 8'h76;
            5'd24: s = 8'h6e;
            5'd25: s = 8'h5b;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] char_seg(logic [7:0] ch);
        logic [7:0] low;
        logic [7:0] s;
        low = ch | 8'h20;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            s = digit_seg(4'(ch - 8'h30));
        end else if (low >= 8'h61 && low <= 8'h7a) begin
            s = alpha_seg(5'(low - 8'h61));
        end else begin
            s = SEG_BLANK;
        end
        return s;
    endfunction

endpackage

// ===== rtl/ssd_front.sv =====
// Input register of the encoder: classifies the request and forms the magnitude.
// Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [1:0]                action,
    input  logic [7:0]                chip_select,
    input  logic [15:0]               value,
    input  logic [7:0]                text_first,
    input  logic [7:0]                text_second,
    input  logic [7:0]                text_third,
    input  logic [7:0]                text_fourth,
    output logic                      valid,
    output ssd_pkg::ctl_t             ctl,
    output logic [ssd_pkg::MAG_W-1:0] mag
);

    logic                      valid_reg;
    ssd_pkg::ctl_t             ctl_reg;
    ssd_pkg::ctl_t             ctl_next;
    logic [ssd_pkg::MAG_W-1:0] mag_reg;
    logic [ssd_pkg::MAG_W-1:0] mag_next;
    logic [15:0]               neg_mag;
    logic [15:0]               num;

    always_comb
    begin
        neg_mag           = ~value + 16'd1;
        num               = value;
        ctl_next.chip     = chip_select;
        ctl_next.kind     = ssd_pkg::KIND_NUM;
        ctl_next.neg      = 1'b0;
        ctl_next.text_seg = {ssd_pkg::char_seg(text_fourth), ssd_pkg::char_seg(text_third),
                             ssd_pkg::char_seg(text_second), ssd_pkg::char_seg(text_first)};
        if (action == ssd_pkg::ACT_UNSIGNED || action == ssd_pkg::ACT_SIGNED) begin
            if (action == ssd_pkg::ACT_SIGNED && value[15]) begin
                num = neg_mag;
                if (neg_mag >= 16'd1000) begin
                    ctl_next.kind = ssd_pkg::KIND_UFLO;
                end else begin
                    ctl_next.neg = 1'b1;
                end
            end else if (value >= 16'd10000) begin
                ctl_next.kind = ssd_pkg::KIND_OFLO;
            end
        end else begin
            ctl_next.kind = ssd_pkg::KIND_TEXT;
        end
        // blanking thresholds of the magnitude
        ctl_next.ge1000 = (num >= 16'd1000);
        ctl_next.ge100  = (num >= 16'd100);
        ctl_next.ge10   = (num >= 16'd10);
        mag_next        = num[ssd_pkg::MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            ctl_reg <= ctl_next;
            mag_reg <= mag_next;
        end
    end

    assign valid = valid_reg;
    assign ctl   = ctl_reg;
    assign mag   = mag_reg;

endmodule

// ===== rtl/ssd_bcd.sv =====
// Three-stage binary-to-decimal pipeline: thousands, hundreds, then tens and ones.
// Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_bcd (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  ssd_pkg::ctl_t             in_ctl,
    input  logic [ssd_pkg::MAG_W-1:0] mag,
    output logic                      out_valid,
    output ssd_pkg::ctl_t             out_ctl,
    output logic [3:0][3:0]           digits
);

    logic [2:0]        valid_reg;
    ssd_pkg::ctl_t     ctl1_reg;
    ssd_pkg::ctl_t     ctl2_reg;
    ssd_pkg::ctl_t     ctl3_reg;
    logic [3:0]        th1_reg;
    logic [9:0]        rem1_reg;
    logic [3:0]        th2_reg;
    logic [3:0]        hu2_reg;
    logic [6:0]        rem2_reg;
    logic [3:0][3:0]   dig3_reg;
    ssd_pkg::dstep_t   step1;
    ssd_pkg::dstep_t   step2;
    ssd_pkg::dstep_t   step3;

    assign step1 = ssd_pkg::digit_step(mag, ssd_pkg::MAG_W'(1000));
    assign step2 = ssd_pkg::digit_step(ssd_pkg::MAG_W'(rem1_reg), ssd_pkg::MAG_W'(100));
    assign step3 = ssd_pkg::digit_step(ssd_pkg::MAG_W'(rem2_reg), ssd_pkg::MAG_W'(10));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 3'b000;
        end else begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // advance every stage each cycle; the valid bits mark live items
    always_ff @(posedge clk)
    begin
        ctl1_reg    <= in_ctl;
        th1_reg     <= step1.digit;
        rem1_reg    <= step1.rest[9:0];
        ctl2_reg    <= ctl1_reg;
        th2_reg     <= th1_reg;
        hu2_reg     <= step2.digit;
        rem2_reg    <= step2.rest[6:0];
        ctl3_reg    <= ctl2_reg;
        dig3_reg[0] <= th2_reg;
        dig3_reg[1] <= hu2_reg;
        dig3_reg[2] <= step3.digit;
        dig3_reg[3] <= step3.rest[3:0];
    end

    assign out_valid = valid_reg[2];
    assign out_ctl   = ctl3_reg;
    assign digits    = dig3_reg;

endmodule

// ===== rtl/ssd_out.sv =====
// Result register: maps digits, sign, text and special patterns to segment bytes.
// Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_out (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  ssd_pkg::ctl_t   ctl,
    input  logic [3:0][3:0] digits,
    output logic            done,
    output logic [7:0]      chip_out,
    output logic [7:0]      segments_left,
    output logic [7:0]      segments_second,
    output logic [7:0]      segments_third,
    output logic [7:0]      segments_right
);

    logic           done_reg;
    logic [7:0]     chip_reg;
    ssd_pkg::seg4_t seg_reg;
    ssd_pkg::seg4_t seg_next;

    always_comb
    begin
        case (ctl.kind)
            ssd_pkg::KIND_OFLO: seg_next = ssd_pkg::PAT_OFLO;
            ssd_pkg::KIND_UFLO: seg_next = ssd_pkg::PAT_UFLO;
            ssd_pkg::KIND_TEXT: seg_next = ctl.text_seg;
            default:
            begin
                seg_next[0] = ctl.ge1000 ? ssd_pkg::digit_seg(digits[0]) : ssd_pkg::SEG_BLANK;
                seg_next[1] = ctl.ge100  ? ssd_pkg::digit_seg(digits[1]) : ssd_pkg::SEG_BLANK;
                seg_next[2] = ctl.ge10   ? ssd_pkg::digit_seg(digits[2]) : ssd_pkg::SEG_BLANK;
                seg_next[3] = ssd_pkg::digit_seg(digits[3]);
                if (ctl.neg) begin
                    seg_next[0] = ssd_pkg::SEG_MINUS;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        chip_reg <= ctl.chip;
        seg_reg  <= seg_next;
    end

    assign done            = done_reg;
    assign chip_out        = chip_reg;
    assign segments_left   = seg_reg[0];
    assign segments_second = seg_reg[1];
    assign segments_third  = seg_reg[2];
    assign segments_right  = seg_reg[3];

endmodule

// ===== rtl/seven_segment_display_encoder.sv =====
// Four-digit seven-segment encoder: number, signed number or text to segment bytes.
// done strobes once per item, after the front, decimal and result registers.
// Throughput: one item per cycle; the decimal split runs in three stages.
// busy stays low, and the receiver cannot stall the result strobe.
// Reset clears the valid bits only; payload registers are not reset.
// Depends on ssd_pkg, ssd_front, ssd_bcd and ssd_out.
`timescale 1ns / 1ps

module seven_segment_display_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [7:0]  chip_select,
    input  logic [15:0] value,
    input  logic [7:0]  text_first,
    input  logic [7:0]  text_second,
    input  logic [7:0]  text_third,
    input  logic [7:0]  text_fourth,
    output logic        done,
    output logic [7:0]  chip_out,
    output logic [7:0]  segments_left,
    output logic [7:0]  segments_second,
    output logic [7:0]  segments_third,
    output logic [7:0]  segments_right
);

    logic                      accept;
    logic                      front_valid;
    ssd_pkg::ctl_t             front_ctl;
    logic [ssd_pkg::MAG_W-1:0] front_mag;
    logic                      bcd_valid;
    ssd_pkg::ctl_t             bcd_ctl;
    logic [3:0][3:0]           bcd_digits;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    ssd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (action),
        .chip_select (chip_select),
        .value       (value),
        .text_first  (text_first),
        .text_second (text_second),
        .text_third  (text_third),
        .text_fourth (text_fourth),
        .valid       (front_valid),
        .ctl         (front_ctl),
        .mag         (front_mag)
    );

    ssd_bcd u_bcd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ctl    (front_ctl),
        .mag       (front_mag),
        .out_valid (bcd_valid),
        .out_ctl   (bcd_ctl),
        .digits    (bcd_digits)
    );

    ssd_out u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (bcd_valid),
        .ctl             (bcd_ctl),
        .digits          (bcd_digits),
        .done            (done),
        .chip_out        (chip_out),
        .segments_left   (segments_left),
        .segments_second (segments_second),
        .segments_third  (segments_third),
        .segments_right  (segments_right)
    );

`ifndef SYNTHESIS
    a_done_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("accepted item produced no result");

    a_done_has_source : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 5))
        else $error("result strobe without an accepted item");

    a_chip_follows : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 (chip_out == $past(chip_select, 5)))
        else $error("chip select not carried with its item");
`endif

endmodule

// ===== verif/tb_seven_segment_display_encoder.sv =====
// Testbench for seven_segment_display_encoder: directed and random requests in all
// four action codes, predicted segment bytes checked against every done strobe.
// Depends on ssd_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_seven_segment_display_encoder;

    // the unassigned action code, decoded as text
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1700;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 100;

    // index 0 is the glyph of '0' and of 'a'
    localparam logic [0:9][7:0] DIGIT_GLYPH = {
        8'hbb, 8'ha0, 8'h37, 8'hb5, 8'hac, 8'h9d, 8'h9f, 8'hb0, 8'hbf, 8'hbd
    };
    localparam logic [0:25][7:0] LETTER_GLYPH = {
        8'h5f, 8'h7c, 8'h58, 8'h5e, 8'h7b, 8'h71, 8'h6f, 8'h74, 8'h04, 8'h0c,
        8'h76, 8'h38, 8'h54, 8'h54, 8'h5c, 8'h73, 8'h67, 8'h50, 8'h6d, 8'h78,
        8'h1c, 8'h3e, 8'h7e, 8'h76, 8'h6e, 8'h5b
    };

    typedef struct {
        logic [1:0]       action;
        logic [7:0]       chip_select;
        logic [15:0]      value;
        logic [0:3][7:0]  text;
        int unsigned      gap;
    } display_req_t;

    typedef struct packed {
        logic [7:0]      chip;
        ssd_pkg::seg4_t  seg;
    } glyph_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  action = '0;
    logic [7:0]  chip_select = '0;
    logic [15:0] value = '0;
    logic [7:0]  text_first = '0;
    logic [7:0]  text_second = '0;
    logic [7:0]  text_third = '0;
    logic [7:0]  text_fourth = '0;
    logic        done;
    logic [7:0]  chip_out;
    logic [7:0]  segments_left;
    logic [7:0]  segments_second;
    logic [7:0]  segments_third;
    logic [7:0]  segments_right;

    display_req_t pending_items[$];
    glyph_word_t  expected_glyphs[$];
    display_req_t on_port;
    glyph_word_t  oldest;
    int unsigned  gap_left = 0;
    bit           gap_loaded = 1'b0;
    bit           item_taken = 1'b0;
    bit           result_seen = 1'b0;
    int unsigned  mismatches = 0;

    seven_segment_display_encoder u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .chip_select     (chip_select),
        .value           (value),
        .text_first      (text_first),
        .text_second     (text_second),
        .text_third      (text_third),
        .text_fourth     (text_fourth),
        .done            (done),
        .chip_out        (chip_out),
        .segments_left   (segments_left),
        .segments_second (segments_second),
        .segments_third  (segments_third),
        .segments_right  (segments_right)
    );

    function automatic logic [7:0] glyph_of_char(logic [7:0] ch);
        logic [7:0] folded;
        folded = ch | 8'h20;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            return DIGIT_GLYPH[4'(ch - 8'h30)];
        end
        if (folded >= 8'h61 && folded <= 8'h7a)
        begin
            return LETTER_GLYPH[5'(folded - 8'h61)];
        end
        return ssd_pkg::SEG_BLANK;
    endfunction

    // mag is 0..9999; blank the leading zeros, always show the ones digit
    function automatic ssd_pkg::seg4_t decimal_glyphs(int unsigned mag);
        ssd_pkg::seg4_t s;
        s[0] = (mag >= 1000) ? DIGIT_GLYPH[4'((mag / 1000) % 10)] : ssd_pkg::SEG_BLANK;
        s[1] = (mag >= 100) ? DIGIT_GLYPH[4'((mag / 100) % 10)] : ssd_pkg::SEG_BLANK;
        s[2] = (mag >= 10) ? DIGIT_GLYPH[4'((mag / 10) % 10)] : ssd_pkg::SEG_BLANK;
        s[3] = DIGIT_GLYPH[4'(mag % 10)];
        return s;
    endfunction

    function automatic glyph_word_t encode_display(display_req_t r);
        glyph_word_t w;
        int unsigned mag;
        w.chip = r.chip_select;
        if (r.action == ssd_pkg::ACT_UNSIGNED || r.action == ssd_pkg::ACT_SIGNED)
        begin
            if (r.action == ssd_pkg::ACT_SIGNED && r.value[15])
            begin
                mag = 32'h10000 - 32'(r.value);
                if (mag >= 1000)
                begin
                    w.seg = ssd_pkg::PAT_UFLO;
                end
                else
                begin
                    w.seg = decimal_glyphs(mag);
                    w.seg[0] = ssd_pkg::SEG_MINUS;
                end
            end
            else if (r.value >= 16'd10000)
            begin
                w.seg = ssd_pkg::PAT_OFLO;
            end
            else
            begin
                w.seg = decimal_glyphs(32'(r.value));
            end
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                w.seg[k] = glyph_of_char(r.text[k]);
            end
        end
        return w;
    endfunction

    // every third stretch of 150 items runs back to back
    task automatic add_request(logic [1:0] act, logic [7:0] chip, logic [15:0] val,
                               logic [0:3][7:0] txt);
        display_req_t r;
        r.action      = act;
        r.chip_select = chip;
        r.value       = val;
        r.text        = txt;
        r.gap         = ((pending_items.size() / 150) % 3 == 1) ? 0 : $urandom_range(0, 3);
        pending_items.push_back(r);
    endtask

    task automatic compare_byte(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s expected %02h, got %02h", $time, field, want, got);
        end
    endtask

    initial
    begin
        forever #1 clk = ~clk;
    end

    // driver: present the oldest pending item after its gap, hold it until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && item_taken)
            begin
                void'(pending_items.pop_front());
                gap_loaded = 1'b0;
            end
            if (start && !item_taken)
            begin
                // hold the item on the ports
            end
            else if (pending_items.size() == 0)
            begin
                start <= 1'b0;
            end
            else
            begin
                if (!gap_loaded)
                begin
                    gap_left   = pending_items[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else
                begin
                    on_port     <= pending_items[0];
                    action      <= pending_items[0].action;
                    chip_select <= pending_items[0].chip_select;
                    value       <= pending_items[0].value;
                    text_first  <= pending_items[0].text[0];
                    text_second <= pending_items[0].text[1];
                    text_third  <= pending_items[0].text[2];
                    text_fourth <= pending_items[0].text[3];
                    start       <= 1'b1;
                end
            end
        end
    end

    // monitor: check each strobe against the oldest prediction, then log the new item
    always @(posedge clk)
    begin
        item_taken  <= rst_n && start && busy === 1'b0;
        result_seen <= rst_n && done === 1'b1;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (expected_glyphs.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result expected none, got chip %02h segs %02h %02h %02h %02h",
                             $time, chip_out, segments_left, segments_second,
                             segments_third, segments_right);
                end
                else
                begin
                    oldest = expected_glyphs.pop_front();
                    compare_byte("chip_out", oldest.chip, chip_out);
                    compare_byte("segments_left", oldest.seg[0], segments_left);
                    compare_byte("segments_second", oldest.seg[1], segments_second);
                    compare_byte("segments_third", oldest.seg[2], segments_third);
                    compare_byte("segments_right", oldest.seg[3], segments_right);
                end
            end
            else if (done !== 1'b0)
            begin
                mismatches++;
                $display("%0t ns: done expected 0 or 1, got %b", $time, done);
            end
            if (start && busy === 1'b0)
            begin
                expected_glyphs.push_back(encode_display(on_port));
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if (item_taken || result_seen
                || (pending_items.size() == 0 && expected_glyphs.size() == 0))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned     pick;
        logic [1:0]      act;
        logic [15:0]     val;
        logic [0:3][7:0] txt;

        // unsigned: digit-count boundaries and overflow
        add_request(ssd_pkg::ACT_UNSIGNED, 8'h00, 16'd0, 32'hffffffff);
        add_request(ssd_pkg::ACT_UNSIGNED, 8'hff, 16'd9, 32'h00000000);
        add_request(ssd_pkg::ACT_UNSIGNED, 8'h5a, 16'd10, "0189");
        add_request(ssd_pkg::ACT_UNSIGNED, 8'ha5, 16'd99, "AZaz");
        add_request(ssd_pkg::ACT_UNSIGNED, 8'h01, 16'd100, 32'h0);
        add_request(ssd_pkg::ACT_UNSIGNED, 8'h80, 16'd999, 32'h0);
        add_request(ssd_pkg::ACT_UNSIGNED, 8'h7f, 16'd1000, 32'h0);
        add_request(ssd_pkg::ACT_UNSIGNED, 8'hfe, 16'd9999, 32'h0);
        add_request(ssd_pkg::ACT_UNSIGNED, 8'h00, 16'd10000, 32'h0);
        add_request(ssd_pkg::ACT_UNSIGNED, 8'hff, 16'hffff, 32'h0);
        // signed: zero, overflow, short negatives, underflow
        add_request(ssd_pkg::ACT_SIGNED, 8'h00, 16'd0, 32'h0);
        add_request(ssd_pkg::ACT_SIGNED, 8'hff, 16'd9999, 32'h0);
        add_request(ssd_pkg::ACT_SIGNED, 8'h33, 16'd10000, 32'h0);
        add_request(ssd_pkg::ACT_SIGNED, 8'hcc, 16'h7fff, 32'h0);
        add_request(ssd_pkg::ACT_SIGNED, 8'h12, 16'hffff, 32'h0);
        add_request(ssd_pkg::ACT_SIGNED, 8'h34, 16'hfff7, 32'h0);
        add_request(ssd_pkg::ACT_SIGNED, 8'h56, 16'hfff6, 32'h0);
        add_request(ssd_pkg::ACT_SIGNED, 8'h78, 16'hfc19, 32'h0);
        add_request(ssd_pkg::ACT_SIGNED, 8'h9a, 16'hfc18, 32'h0);
        add_request(ssd_pkg::ACT_SIGNED, 8'hbc, 16'h8000, 32'hffffffff);
        // text: digits, letter extremes, neighbors of the printable ranges
        add_request(ssd_pkg::ACT_TEXT, 8'h00, 16'hffff, "0189");
        add_request(ssd_pkg::ACT_TEXT, 8'hff, 16'h0000, "AZaz");
        add_request(ssd_pkg::ACT_TEXT, 8'h11, 16'h1234, {8'h2f, 8'h3a, 8'h40, 8'h5b});
        add_request(ACT_SPARE, 8'hee, 16'h4321, {8'h60, 8'h7b, 8'h00, 8'hff});

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                act = ssd_pkg::ACT_UNSIGNED;
            else if (pick < 6)
                act = ssd_pkg::ACT_SIGNED;
            else if (pick < 9)
                act = ssd_pkg::ACT_TEXT;
            else
                act = ACT_SPARE;
            case ($urandom_range(0, 5))
                0: val = 16'($urandom_range(0, 9999));
                1: val = 16'($urandom_range(0, 120));
                2: val = 16'(32'h10000 - $urandom_range(1, 999));
                3: val = 16'($urandom_range(9990, 10010));
                4: val = 16'(32'h10000 - $urandom_range(990, 1010));
                default: val = 16'($urandom());
            endcase
            for (int k = 0; k < 4; k++)
            begin
                case ($urandom_range(0, 3))
                    0: txt[k] = 8'(8'h30 + $urandom_range(0, 9));
                    1: txt[k] = 8'(8'h41 + $urandom_range(0, 25));
                    2: txt[k] = 8'(8'h61 + $urandom_range(0, 25));
                    default: txt[k] = 8'($urandom());
                endcase
            end
            add_request(act, 8'($urandom()), val, txt);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || expected_glyphs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ssd_pkg.sv
rtl/ssd_front.sv
rtl/ssd_bcd.sv
rtl/ssd_out.sv
rtl/seven_segment_display_encoder.sv
verif/tb_seven_segment_display_encoder.sv
